[hw/rtl/fsts_pkg.sv]
// fsts_pkg: shared types, codes and defaults of the fixed-step tick scheduler
`default_nettype none
package fsts_pkg;

    localparam int unsigned MAX_ENTRIES_DEF   = 16;
    localparam int unsigned TIME_BITS_DEF     = 24;
    localparam int unsigned FRACTION_BITS_DEF = 16;
    localparam int unsigned ID_BITS_DEF       = 16;
    localparam int unsigned CATCH_UP_BITS     = 8;
    localparam logic [CATCH_UP_BITS-1:0] CATCH_UP_RESET = 8'd8;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_ADVANCE = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_OUT,
        S_FULL_OUT,
        S_RM_RD,
        S_RM_CMP,
        S_SH_RD,
        S_SH_WR,
        S_AD_RD,
        S_AD_LOAD,
        S_AD_DIV,
        S_AD_OUT
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic idx_clr;
        logic idx_inc;
        logic rd_next;
        logic wr_add;
        logic wr_shift;
        logic wr_back;
        logic div_start;
        logic div_step;
        logic out_add;
        logic out_full;
        logic out_adv;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    id_zero;
        logic    full;
        logic    empty;
        logic    match;
        logic    idx_last;
        logic    idx_last2;
        logic    ticking;
        logic    div_done;
        logic    out_free;
    } t_sts;

endpackage
`default_nettype wire

[hw/rtl/fsts_if.sv]
// fsts_in_if and fsts_out_if: request and result channels
`default_nettype none
interface fsts_in_if #(
    parameter int unsigned ID_BITS   = fsts_pkg::ID_BITS_DEF,
    parameter int unsigned TIME_BITS = fsts_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [ID_BITS-1:0]   client_id;
    logic [TIME_BITS-1:0] interval;
    logic                 wants_tick;
    logic                 wants_update;
    logic                 wants_attach;
    logic [TIME_BITS-1:0] elapsed;

    modport source (output valid, action, client_id, interval, wants_tick, wants_update,
                    wants_attach, elapsed, input ready);
    modport sink (input valid, action, client_id, interval, wants_tick, wants_update,
                  wants_attach, elapsed, output ready);
endinterface

interface fsts_out_if #(
    parameter int unsigned ID_BITS       = fsts_pkg::ID_BITS_DEF,
    parameter int unsigned TIME_BITS     = fsts_pkg::TIME_BITS_DEF,
    parameter int unsigned FRACTION_BITS = fsts_pkg::FRACTION_BITS_DEF
);
    logic                                   valid;
    logic                                   ready;
    logic [ID_BITS-1:0]                     out_client;
    logic [fsts_pkg::CATCH_UP_BITS-1:0]     tick_count;
    logic [TIME_BITS-1:0]                   tick_length;
    logic [FRACTION_BITS-1:0]               phase_fraction;
    logic                                   call_update;
    logic                                   call_attach;
    logic                                   table_full;
    logic                                   last;

    modport source (output valid, out_client, tick_count, tick_length, phase_fraction,
                    call_update, call_attach, table_full, last, input ready);
    modport sink (input valid, out_client, tick_count, tick_length, phase_fraction,
                  call_update, call_attach, table_full, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/fsts_ctrl.sv]
// fsts_ctrl: sequencing state machine for add, remove, clear and advance
`default_nettype none
module fsts_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire fsts_pkg::t_sts i_sts,
    output fsts_pkg::t_cmd      o_cmd
);

    fsts_pkg::t_state r_state;
    fsts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fsts_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = fsts_pkg::S_DISPATCH;
                end
            end
            fsts_pkg::S_DISPATCH: begin
                case (i_sts.act)
                    fsts_pkg::ACT_ADD: begin
                        if (i_sts.id_zero) begin
                            n_state = fsts_pkg::S_IDLE;
                        end else if (i_sts.full) begin
                            n_state = fsts_pkg::S_FULL_OUT;
                        end else begin
                            o_cmd.wr_add  = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                            n_state       = fsts_pkg::S_ADD_OUT;
                        end
                    end
                    fsts_pkg::ACT_REMOVE: begin
                        if (i_sts.id_zero || i_sts.empty) begin
                            n_state = fsts_pkg::S_IDLE;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = fsts_pkg::S_RM_RD;
                        end
                    end
                    fsts_pkg::ACT_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = fsts_pkg::S_IDLE;
                    end
                    default: begin
                        if (i_sts.empty) begin
                            n_state = fsts_pkg::S_IDLE;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = fsts_pkg::S_AD_RD;
                        end
                    end
                endcase
            end
            fsts_pkg::S_ADD_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_add = 1'b1;
                    n_state       = fsts_pkg::S_IDLE;
                end
            end
            fsts_pkg::S_FULL_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_full = 1'b1;
                    n_state        = fsts_pkg::S_IDLE;
                end
            end
            fsts_pkg::S_RM_RD: begin
                n_state = fsts_pkg::S_RM_CMP;
            end
            fsts_pkg::S_RM_CMP: begin
                if (i_sts.match) begin
                    if (i_sts.idx_last) begin
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = fsts_pkg::S_IDLE;
                    end else begin
                        n_state = fsts_pkg::S_SH_RD;
                    end
                end else if (i_sts.idx_last) begin
                    n_state = fsts_pkg::S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = fsts_pkg::S_RM_RD;
                end
            end
            fsts_pkg::S_SH_RD: begin
                o_cmd.rd_next = 1'b1;
                n_state       = fsts_pkg::S_SH_WR;
            end
            fsts_pkg::S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                if (i_sts.idx_last2) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = fsts_pkg::S_IDLE;
                end else begin
                    n_state = fsts_pkg::S_SH_RD;
                end
            end
            fsts_pkg::S_AD_RD: begin
                n_state = fsts_pkg::S_AD_LOAD;
            end
            fsts_pkg::S_AD_LOAD: begin
                if (i_sts.ticking) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = fsts_pkg::S_AD_DIV;
                end else begin
                    n_state = fsts_pkg::S_AD_OUT;
                end
            end
            fsts_pkg::S_AD_DIV: begin
                if (i_sts.div_done) begin
                    n_state = fsts_pkg::S_AD_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            fsts_pkg::S_AD_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_adv = 1'b1;
                    o_cmd.wr_back = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = fsts_pkg::S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = fsts_pkg::S_AD_RD;
                    end
                end
            end
            default: begin
                n_state = fsts_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/fsts_dp.sv]
// fsts_dp: entry table, serial divider, request latch and result register
`default_nettype none
module fsts_dp #(
    parameter int unsigned MAX_ENTRIES   = fsts_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned TIME_BITS     = fsts_pkg::TIME_BITS_DEF,
    parameter int unsigned FRACTION_BITS = fsts_pkg::FRACTION_BITS_DEF,
    parameter int unsigned ID_BITS       = fsts_pkg::ID_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [fsts_pkg::CATCH_UP_BITS-1:0] i_cfg_data,
    input  wire fsts_pkg::t_cmd                     i_cmd,
    output fsts_pkg::t_sts                          o_sts,
    fsts_in_if.sink                                 i_in,
    fsts_out_if.source                              o_out
);

    localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned AW = TIME_BITS + 1;
    localparam int unsigned EW = ID_BITS + TIME_BITS + AW + 2;
    localparam int unsigned DS = AW + FRACTION_BITS;
    localparam int unsigned SW = $clog2(DS + 1);
    localparam int unsigned MB = fsts_pkg::CATCH_UP_BITS;

    logic [MB-1:0]         r_max;
    fsts_pkg::t_action     r_act;
    logic [ID_BITS-1:0]    r_id;
    logic [TIME_BITS-1:0]  r_iv_in;
    logic [1:0]            r_flags_in;
    logic                  r_att;
    logic [TIME_BITS-1:0]  r_elapsed;
    logic [CW-1:0]         r_count;
    logic [IW-1:0]         r_idx;
    logic [EW-1:0]         r_mem [MAX_ENTRIES];
    logic [EW-1:0]         r_rdata;
    logic [TIME_BITS-1:0]  r_rem;
    logic [DS-1:0]         r_div;
    logic [DS-1:0]         r_quo;
    logic [SW-1:0]         r_step;
    logic [AW-1:0]         r_acc_new;
    logic                  r_o_valid;
    logic [ID_BITS-1:0]    r_o_client;
    logic [MB-1:0]         r_o_ticks;
    logic [TIME_BITS-1:0]  r_o_len;
    logic [FRACTION_BITS-1:0] r_o_frac;
    logic                  r_o_upd;
    logic                  r_o_att;
    logic                  r_o_full;
    logic                  r_o_last;

    logic [ID_BITS-1:0]    e_id;
    logic [TIME_BITS-1:0]  e_iv;
    logic [AW-1:0]         e_acc;
    logic [1:0]            e_flags;
    logic [IW-1:0]         raddr;
    logic [IW-1:0]         waddr;
    logic [EW-1:0]         wdata;
    logic                  wen;
    logic [AW-1:0]         sum;
    logic [AW-1:0]         rem_sh;
    logic [AW-1:0]         rem_diff;
    logic                  ge;
    logic [TIME_BITS-1:0]  n_rem;
    logic [AW-1:0]         quot;
    logic [MB-1:0]         ticks;
    logic                  ticking;
    logic [CW:0]           idx_p1;
    logic [CW:0]           idx_p2;
    logic                  out_free;

    assign {e_id, e_iv, e_acc, e_flags} = r_rdata;
    assign ticking = e_flags[0] && (e_iv != '0);
    assign idx_p1  = (CW + 1)'(r_idx) + (CW + 1)'(1);
    assign idx_p2  = (CW + 1)'(r_idx) + (CW + 1)'(2);
    assign out_free = !r_o_valid || o_out.ready;
    assign raddr   = i_cmd.rd_next ? idx_p1[IW-1:0] : r_idx;

    always_comb begin
        wen   = 1'b0;
        waddr = r_idx;
        wdata = r_rdata;
        if (i_cmd.wr_add) begin
            wen   = 1'b1;
            waddr = r_count[IW-1:0];
            wdata = {r_id, r_iv_in, {AW{1'b0}}, r_flags_in};
        end else if (i_cmd.wr_shift) begin
            wen = 1'b1;
        end else if (i_cmd.wr_back) begin
            wen   = 1'b1;
            wdata = {e_id, e_iv, (ticking ? r_acc_new : e_acc), e_flags};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    assign sum      = e_acc + AW'(r_elapsed);
    assign rem_sh   = {r_rem, r_div[DS-1]};
    assign rem_diff = rem_sh - {1'b0, e_iv};
    assign ge       = rem_sh >= {1'b0, e_iv};
    assign n_rem    = ge ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
    assign quot     = r_quo[DS-1:FRACTION_BITS];
    assign ticks    = (quot > AW'(r_max)) ? r_max : quot[MB-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div  <= {sum, {FRACTION_BITS{1'b0}}};
            r_rem  <= '0;
            r_quo  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_div  <= {r_div[DS-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quo  <= {r_quo[DS-2:0], ge};
            r_step <= r_step + SW'(1);
            if (r_step == SW'(AW - 1)) begin
                r_acc_new <= {1'b0, n_rem};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_act      <= fsts_pkg::t_action'(i_in.action);
            r_id       <= i_in.client_id;
            r_iv_in    <= i_in.interval;
            r_flags_in <= {i_in.wants_update, i_in.wants_tick};
            r_att      <= i_in.wants_attach;
            r_elapsed  <= i_in.elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= fsts_pkg::CATCH_UP_RESET;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_add || i_cmd.out_full || i_cmd.out_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_add || i_cmd.out_full) begin
            r_o_client <= r_id;
            r_o_ticks  <= '0;
            r_o_len    <= r_iv_in;
            r_o_frac   <= '0;
            r_o_upd    <= 1'b0;
            r_o_att    <= i_cmd.out_add && r_att;
            r_o_full   <= i_cmd.out_full;
            r_o_last   <= 1'b1;
        end else if (i_cmd.out_adv) begin
            r_o_client <= e_id;
            r_o_ticks  <= ticking ? ticks : '0;
            r_o_len    <= e_iv;
            r_o_frac   <= ticking ? r_quo[FRACTION_BITS-1:0] : '0;
            r_o_upd    <= e_flags[1];
            r_o_att    <= 1'b0;
            r_o_full   <= 1'b0;
            r_o_last   <= idx_p1 == (CW + 1)'(r_count);
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.out_client     = r_o_client;
    assign o_out.tick_count     = r_o_ticks;
    assign o_out.tick_length    = r_o_len;
    assign o_out.phase_fraction = r_o_frac;
    assign o_out.call_update    = r_o_upd;
    assign o_out.call_attach    = r_o_att;
    assign o_out.table_full     = r_o_full;
    assign o_out.last           = r_o_last;

    always_comb begin
        o_sts           = '0;
        o_sts.act       = r_act;
        o_sts.id_zero   = r_id == '0;
        o_sts.full      = r_count == CW'(MAX_ENTRIES);
        o_sts.empty     = r_count == '0;
        o_sts.match     = e_id == r_id;
        o_sts.idx_last  = idx_p1 == (CW + 1)'(r_count);
        o_sts.idx_last2 = idx_p2 == (CW + 1)'(r_count);
        o_sts.ticking   = ticking;
        o_sts.div_done  = r_step == SW'(DS);
        o_sts.out_free  = out_free;
    end

endmodule
`default_nettype wire

[hw/rtl/fixed_step_tick_scheduler_top.sv]
// fixed_step_tick_scheduler_top: client table with fixed-step tick scheduling
`default_nettype none
// One request is handled at a time; the block takes a new request once the
// previous one is done, even while its last result still waits to be taken.
// Add writes the entry, or flags a full table, and posts its result; clear only
// resets the count. Remove reads and compares entries up to the match, then
// moves each later one down with a read and a write. Advance reads each entry,
// divides if it ticks and posts its result: the tick count, the new accumulator
// and the phase come from one restoring divider that retires one quotient bit a
// cycle. Results are held in an output register, so a stalled sink only pauses the walk.
module fixed_step_tick_scheduler_top #(
    parameter int unsigned MAX_ENTRIES   = fsts_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned TIME_BITS     = fsts_pkg::TIME_BITS_DEF,
    parameter int unsigned FRACTION_BITS = fsts_pkg::FRACTION_BITS_DEF,
    parameter int unsigned ID_BITS       = fsts_pkg::ID_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [fsts_pkg::CATCH_UP_BITS-1:0] i_cfg_data,
    fsts_in_if.sink                                 i_in,
    fsts_out_if.source                              o_out
);

    fsts_pkg::t_cmd cmd;
    fsts_pkg::t_sts sts;

    fsts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fsts_dp #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .TIME_BITS     (TIME_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .ID_BITS       (ID_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in       (i_in),
        .o_out      (o_out)
    );

`ifndef SYNTHESIS
    a_no_add_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cnt_inc |-> !sts.full)
        else $error("entry appended to a full table");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_add || cmd.out_full || cmd.out_adv) |-> sts.out_free)
        else $error("result register overwritten before it was taken");

    a_div_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> !sts.div_done)
        else $error("divider stepped past its last quotient bit");

    a_ready_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.latch_in |=> !i_in.ready)
        else $error("request taken while the previous one is still open");
`endif

endmodule
`default_nettype wire
